### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the parser checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define COAPMP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define COAPMP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define COAPMP_ASSERT_ALWAYS_NXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/coapmp_pkg.sv
// ---------------------------------------------------------------------------
// coapmp_pkg
// types, record codes and constants of the message parser
// ---------------------------------------------------------------------------
`default_nettype none

package coapmp_pkg;

   localparam int MAX_OPTIONS_DEFAULT = 16;
   // token bytes past this count are dropped
   localparam int MAX_TOKEN_BYTES = 8;

   localparam logic [2:0] KIND_HEADER    = 3'd0;
   localparam logic [2:0] KIND_TOKEN     = 3'd1;
   localparam logic [2:0] KIND_OPT_START = 3'd2;
   localparam logic [2:0] KIND_OPT_VALUE = 3'd3;
   localparam logic [2:0] KIND_PAYLOAD   = 3'd4;
   localparam logic [2:0] KIND_END       = 3'd5;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_LEN_ERR = 1'b1;

   localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
   localparam logic [3:0]  NIB_EXT8       = 4'd13;
   localparam logic [3:0]  NIB_EXT16      = 4'd14;
   localparam logic [15:0] EXT8_BASE      = 16'd13;
   localparam logic [15:0] EXT16_BASE     = 16'd269;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TOKEN,
      PH_OPT_HEAD,
      PH_DELTA_EXT,
      PH_LEN_EXT,
      PH_VALUE,
      PH_PAYLOAD,
      PH_IGNORE
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } coapmp_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  version;
      logic [1:0]  msg_type;
      logic [3:0]  token_length;
      logic [7:0]  code;
      logic [15:0] message_id;
      logic [15:0] option_number;
      logic [15:0] option_length;
      logic [7:0]  byte_value;
      logic        status;
      logic [15:0] payload_length;
      logic        last_result;
   } coapmp_rsp_type;

   // what one input word produces: an optional record and an optional end record
   typedef struct packed {
      logic           have;
      coapmp_rsp_type rec;
      logic           fin;
      coapmp_rsp_type end_rec;
   } coapmp_pair_type;

endpackage

`default_nettype wire

### sv/coapmp_in_reg.sv
// ---------------------------------------------------------------------------
// coapmp_in_reg
// input word register in front of the decoder
// ---------------------------------------------------------------------------
`default_nettype none

module coapmp_in_reg
   import coapmp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  coapmp_req_type req_data,
   input  logic           load_ok,
   output coapmp_req_type word,
   output logic           fire
);

   logic           valid_ff, valid_in;
   coapmp_req_type word_ff, word_in;
   logic           take;

   assign fire      = valid_ff && load_ok;
   assign req_stall = valid_ff && !load_ok;
   assign take      = req_valid && !req_stall;
   assign word      = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (take) begin
         valid_in = 1'b1;
         word_in  = req_data;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule

`default_nettype wire

### sv/coapmp_decode.sv
// ---------------------------------------------------------------------------
// coapmp_decode
// parse state and per-byte decode into records
// ---------------------------------------------------------------------------
`default_nettype none

module coapmp_decode
   import coapmp_pkg::*;
#(
   parameter int MAX_OPTIONS = MAX_OPTIONS_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  coapmp_req_type  word,
   output coapmp_pair_type pair
);

   localparam int               OptW          = $clog2(MAX_OPTIONS + 1);
   localparam logic [OptW-1:0]  OptLimit      = OptW'(MAX_OPTIONS);
   localparam logic [3:0]       HeaderLastIdx = 4'd3;
   localparam logic [3:0]       TokenKeep     = 4'(MAX_TOKEN_BYTES);

   phase_type       phase_ff, phase_in, phase_step;
   logic [3:0]      count_ff, count_in;
   logic [23:0]     hdr_ff, hdr_in;
   logic [3:0]      tok_left_ff, tok_left_in;
   logic [15:0]     onum_ff, onum_in;
   logic [3:0]      dnib_ff, dnib_in;
   logic [3:0]      lnib_ff, lnib_in;
   logic [7:0]      acc_ff, acc_in;
   logic [15:0]     vleft_ff, vleft_in;
   logic [OptW-1:0] opts_ff, opts_in;
   logic [15:0]     pay_ff, pay_in, pay_step;

   logic [7:0]  b;
   logic        last;
   logic [7:0]  b0;
   logic        is_marker, opts_full, head_ext;
   logic        num_done, len_ext_eff, len_done, finish;
   logic [3:0]  lnib_eff;
   logic [15:0] delta_add, onum_sum, opt_num, opt_len;
   logic        len_err;

   assign b         = word.data_byte;
   assign last      = word.last_byte;
   assign b0        = hdr_ff[23:16];
   assign is_marker = (b == PAYLOAD_MARKER);
   assign opts_full = (opts_ff >= OptLimit);
   assign head_ext  = (b[7:4] == NIB_EXT8) || (b[7:4] == NIB_EXT16);

   // option number is complete on this byte
   assign num_done = ((phase_ff == PH_OPT_HEAD) && !is_marker && !opts_full && !head_ext)
      || ((phase_ff == PH_DELTA_EXT) && ((dnib_ff == NIB_EXT8) || count_ff[0]));

   always_comb begin
      if (phase_ff == PH_OPT_HEAD) begin
         delta_add = {12'd0, b[7:4]};
      end else if (dnib_ff == NIB_EXT8) begin
         delta_add = EXT8_BASE + {8'd0, b};
      end else begin
         delta_add = EXT16_BASE + {acc_ff, b};
      end
   end

   assign onum_sum    = onum_ff + delta_add;
   assign opt_num     = num_done ? onum_sum : onum_ff;
   assign lnib_eff    = (phase_ff == PH_OPT_HEAD) ? b[3:0] : lnib_ff;
   assign len_ext_eff = (lnib_eff == NIB_EXT8) || (lnib_eff == NIB_EXT16);
   assign len_done    = (phase_ff == PH_LEN_EXT) && ((lnib_ff == NIB_EXT8) || count_ff[0]);
   assign finish      = (num_done && !len_ext_eff) || len_done;

   always_comb begin
      if (phase_ff != PH_LEN_EXT) begin
         opt_len = {12'd0, lnib_eff};
      end else if (lnib_ff == NIB_EXT8) begin
         opt_len = EXT8_BASE + {8'd0, b};
      end else begin
         opt_len = EXT16_BASE + {acc_ff, b};
      end
   end

   assign pay_step = ((phase_ff == PH_PAYLOAD) && (pay_ff != 16'hFFFF)) ? pay_ff + 16'd1
                                                                        : pay_ff;

   // next phase
   always_comb begin
      phase_step = phase_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (count_ff == HeaderLastIdx) begin
               phase_step = (b0[3:0] != 4'd0) ? PH_TOKEN : PH_OPT_HEAD;
            end
         end
         PH_TOKEN: begin
            if (tok_left_ff <= 4'd1) begin
               phase_step = PH_OPT_HEAD;
            end
         end
         PH_OPT_HEAD, PH_DELTA_EXT: begin
            if ((phase_ff == PH_OPT_HEAD) && is_marker) begin
               phase_step = PH_PAYLOAD;
            end else if ((phase_ff == PH_OPT_HEAD) && opts_full) begin
               phase_step = PH_IGNORE;
            end else if (!num_done) begin
               phase_step = PH_DELTA_EXT;
            end else if (len_ext_eff) begin
               phase_step = PH_LEN_EXT;
            end else begin
               phase_step = (opt_len != 16'd0) ? PH_VALUE : PH_OPT_HEAD;
            end
         end
         PH_LEN_EXT: begin
            if (len_done) begin
               phase_step = (opt_len != 16'd0) ? PH_VALUE : PH_OPT_HEAD;
            end
         end
         PH_VALUE: begin
            if (vleft_ff <= 16'd1) begin
               phase_step = PH_OPT_HEAD;
            end
         end
         default: begin
            phase_step = phase_ff;
         end
      endcase
   end

   always_comb begin
      if (!fire) begin
         phase_in = phase_ff;
      end else if (last) begin
         phase_in = PH_HEADER;
      end else begin
         phase_in = phase_step;
      end
   end

   // datapath next values
   always_comb begin
      count_in    = count_ff;
      hdr_in      = hdr_ff;
      tok_left_in = tok_left_ff;
      onum_in     = onum_ff;
      dnib_in     = dnib_ff;
      lnib_in     = lnib_ff;
      acc_in      = acc_ff;
      vleft_in    = vleft_ff;
      opts_in     = opts_ff;
      pay_in      = pay_ff;
      if (fire) begin
         case (phase_ff)
            PH_HEADER: begin
               if (count_ff == HeaderLastIdx) begin
                  tok_left_in = b0[3:0];
                  count_in    = 4'd0;
               end else begin
                  hdr_in   = {hdr_ff[15:0], b};
                  count_in = count_ff + 4'd1;
               end
            end
            PH_TOKEN: begin
               count_in    = count_ff + 4'd1;
               tok_left_in = (tok_left_ff != 4'd0) ? tok_left_ff - 4'd1 : 4'd0;
            end
            PH_OPT_HEAD: begin
               if (!is_marker && !opts_full) begin
                  dnib_in = b[7:4];
                  lnib_in = b[3:0];
                  if (head_ext) begin
                     count_in = 4'd0;
                  end
               end
            end
            PH_DELTA_EXT, PH_LEN_EXT: begin
               if (!num_done && !len_done) begin
                  acc_in   = b;
                  count_in = 4'd1;
               end
            end
            PH_VALUE: begin
               vleft_in = (vleft_ff != 16'd0) ? vleft_ff - 16'd1 : 16'd0;
            end
            PH_PAYLOAD: begin
               pay_in = pay_step;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
         if (num_done) begin
            onum_in = onum_sum;
            if (len_ext_eff) begin
               count_in = 4'd0;
            end
         end
         if (finish) begin
            vleft_in = opt_len;
            if (opts_ff != OptLimit) begin
               opts_in = opts_ff + OptW'(1);
            end
         end
         if (last) begin
            count_in    = 4'd0;
            tok_left_in = 4'd0;
            onum_in     = 16'd0;
            dnib_in     = 4'd0;
            lnib_in     = 4'd0;
            acc_in      = 8'd0;
            vleft_in    = 16'd0;
            opts_in     = '0;
            pay_in      = 16'd0;
         end
      end
   end

   // records
   assign len_err = (phase_step == PH_HEADER) || (phase_step == PH_TOKEN)
      || (phase_step == PH_DELTA_EXT) || (phase_step == PH_LEN_EXT)
      || (phase_step == PH_VALUE);

   always_comb begin
      pair      = '0;
      pair.fin  = last;
      case (phase_ff)
         PH_HEADER: begin
            if (count_ff == HeaderLastIdx) begin
               pair.have             = 1'b1;
               pair.rec.kind         = KIND_HEADER;
               pair.rec.version      = b0[7:6];
               pair.rec.msg_type     = b0[5:4];
               pair.rec.token_length = b0[3:0];
               pair.rec.code         = hdr_ff[15:8];
               pair.rec.message_id   = {hdr_ff[7:0], b};
            end
         end
         PH_TOKEN: begin
            if (count_ff < TokenKeep) begin
               pair.have           = 1'b1;
               pair.rec.kind       = KIND_TOKEN;
               pair.rec.byte_value = b;
            end
         end
         PH_OPT_HEAD, PH_DELTA_EXT, PH_LEN_EXT: begin
            if (finish) begin
               pair.have              = 1'b1;
               pair.rec.kind          = KIND_OPT_START;
               pair.rec.option_number = opt_num;
               pair.rec.option_length = opt_len;
            end
         end
         PH_VALUE: begin
            pair.have           = 1'b1;
            pair.rec.kind       = KIND_OPT_VALUE;
            pair.rec.byte_value = b;
         end
         PH_PAYLOAD: begin
            pair.have           = 1'b1;
            pair.rec.kind       = KIND_PAYLOAD;
            pair.rec.byte_value = b;
         end
         default: begin
            pair.have = 1'b0;
         end
      endcase
      pair.rec.last_result        = !last;
      pair.end_rec.kind           = KIND_END;
      pair.end_rec.status         = len_err ? STATUS_LEN_ERR : STATUS_OK;
      pair.end_rec.payload_length = len_err ? 16'd0 : pay_step;
      pair.end_rec.last_result    = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         count_ff    <= 4'd0;
         tok_left_ff <= 4'd0;
         onum_ff     <= 16'd0;
         dnib_ff     <= 4'd0;
         lnib_ff     <= 4'd0;
         acc_ff      <= 8'd0;
         vleft_ff    <= 16'd0;
         opts_ff     <= '0;
         pay_ff      <= 16'd0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         tok_left_ff <= tok_left_in;
         onum_ff     <= onum_in;
         dnib_ff     <= dnib_in;
         lnib_ff     <= lnib_in;
         acc_ff      <= acc_in;
         vleft_ff    <= vleft_in;
         opts_ff     <= opts_in;
         pay_ff      <= pay_in;
      end
      hdr_ff <= hdr_in;
   end

endmodule

`default_nettype wire

### sv/coapmp_out_buf.sv
// ---------------------------------------------------------------------------
// coapmp_out_buf
// two-slot result register, sends record then end record
// ---------------------------------------------------------------------------
`default_nettype none

module coapmp_out_buf
   import coapmp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  coapmp_pair_type pair,
   output logic            load_ok,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output coapmp_rsp_type  rsp_data
);

   logic           s0_v_ff, s0_v_in, s1_v_ff, s1_v_in;
   coapmp_rsp_type s0_ff, s0_in, s1_ff, s1_in;
   logic           pop;

   assign rsp_valid = s0_v_ff || s1_v_ff;
   assign rsp_data  = s0_v_ff ? s0_ff : s1_ff;
   assign pop       = rsp_valid && !rsp_stall;
   // room only when the buffer is empty after this cycle
   assign load_ok   = !(s0_v_ff && s1_v_ff) && (!rsp_valid || pop);

   always_comb begin
      s0_v_in = s0_v_ff;
      s1_v_in = s1_v_ff;
      s0_in   = s0_ff;
      s1_in   = s1_ff;
      if (pop) begin
         if (s0_v_ff) begin
            s0_v_in = 1'b0;
         end else begin
            s1_v_in = 1'b0;
         end
      end
      if (load) begin
         s0_v_in = pair.have;
         s1_v_in = pair.fin;
         s0_in   = pair.rec;
         s1_in   = pair.end_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= s0_v_in;
         s1_v_ff <= s1_v_in;
      end
      s0_ff <= s0_in;
      s1_ff <= s1_in;
   end

endmodule

`default_nettype wire

### sv/coap_message_parser.sv
// ---------------------------------------------------------------------------
// coap_message_parser
// byte-serial message parser: header, token, options, payload, end record
// ---------------------------------------------------------------------------
//
//   channel  ports                          word
//   -------  -----------------------------  ------------------------------
//   req      req_valid  req_stall  req_data  one message byte + last mark
//   rsp      rsp_valid  rsp_stall  rsp_data  one record (header, token,
//                                            option, value, payload, end)
//
// one byte per cycle sustained while rsp_stall stays low; an accepted byte is held
// in the input register, then its records in the result register before leaving
// a last byte that also yields its own record stalls the input while both records
// wait; reset is synchronous and clears all parse state but the header bytes
// req_stall is high when the input register is full and the result register
// cannot be emptied this cycle, so rsp_stall backs up into req_stall
// ---------------------------------------------------------------------------
`default_nettype none

module coap_message_parser
   import coapmp_pkg::*;
#(
   parameter int MAX_OPTIONS = MAX_OPTIONS_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  coapmp_req_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output coapmp_rsp_type rsp_data
);

   // decoded word currently held in the input register
   coapmp_req_type  word;
   // decoder advances on this word this cycle
   logic            fire;
   // result register will be empty after this cycle
   logic            load_ok;
   // record and end record produced by the held word
   coapmp_pair_type pair;

   // input register
   coapmp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .load_ok   (load_ok),
      .word      (word),
      .fire      (fire)
   );

   // parse state and per-byte decode
   coapmp_decode #(
      .MAX_OPTIONS (MAX_OPTIONS)
   ) u_decode (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .word  (word),
      .pair  (pair)
   );

   // result register; the end record follows the byte's own record
   coapmp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .pair      (pair),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### sv/coapmp_checker.sv
// ---------------------------------------------------------------------------
// coapmp_checker
// port-level checks on the parser result channel
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module coapmp_checker
   import coapmp_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           rsp_valid,
   input logic           rsp_stall,
   input coapmp_rsp_type rsp_data
);

   `COAPMP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled result word changed")
   `COAPMP_ASSERT_IMP(a_end_last, clock, reset, rsp_valid && (rsp_data.kind == KIND_END),
      rsp_data.last_result, "end record without last mark")
   `COAPMP_ASSERT_IMP(a_err_len, clock, reset,
      rsp_valid && (rsp_data.kind == KIND_END) && (rsp_data.status == STATUS_LEN_ERR),
      rsp_data.payload_length == 16'd0, "error end with payload length")
   `COAPMP_ASSERT_NXT(a_end_follows, clock, reset,
      rsp_valid && !rsp_stall && !rsp_data.last_result,
      rsp_valid && (rsp_data.kind == KIND_END), "end record not next")
   `COAPMP_ASSERT_ALWAYS_NXT(a_reset_empty, clock, reset, !rsp_valid, "result valid after reset")

endmodule

bind coap_message_parser coapmp_checker u_checker (.*);

`default_nettype wire

### tb/sv/tb_coap_message_parser.sv
// ---------------------------------------------------------------------------
// tb_coap_message_parser
// drives byte streams into the message parser and checks every record
// ---------------------------------------------------------------------------
// A few hand-made messages go in first: a short header, a token cut off, an
// option cut off in its value and in its length extension, nibble fifteen, an
// option that ends with the message, and a bare marker. Random messages
// follow, most of them well formed (long tokens, extended deltas and lengths,
// wrapping sums, the option limit), some cut short and some pure noise.
// A tracker class predicts the records of each accepted word and checks the
// records that come out against them in order.
// ---------------------------------------------------------------------------

module tb_coap_message_parser;
   import coapmp_pkg::*;

   class coap_record_tracker;
      // parse state, mirrors the block after each accepted word
      phase_type   ph;
      logic [15:0] ph_count;
      logic [23:0] hdr;
      logic [3:0]  tok_left;
      logic [15:0] opt_num;
      logic [3:0]  delta_nib;
      logic [3:0]  len_nib;
      logic [15:0] ext_acc;
      logic [15:0] val_left;
      logic [6:0]  opt_seen;
      logic [15:0] pay_count;

      int opt_limit;
      coapmp_rsp_type records_due[$];
      coapmp_rsp_type rec;
      bit have;

      int errors;
      int checked;
      int words;
      int parsed_bytes;
      int messages;
      int len_errors;
      int opt_starts;

      function new(int max_opts);
         opt_limit = max_opts;
         clear_state();
      endfunction

      function void clear_state();
         ph        = PH_HEADER;
         ph_count  = '0;
         hdr       = '0;
         tok_left  = '0;
         opt_num   = '0;
         delta_nib = '0;
         len_nib   = '0;
         ext_acc   = '0;
         val_left  = '0;
         opt_seen  = '0;
         pay_count = '0;
      endfunction

      function void finish_option();
         val_left = ext_acc;
         rec.kind = KIND_OPT_START;
         rec.option_number = opt_num;
         rec.option_length = val_left;
         have = 1'b1;
         opt_starts++;
         if (opt_seen < 7'd127) opt_seen++;
         ph = (val_left != 16'd0) ? PH_VALUE : PH_OPT_HEAD;
      endfunction

      function void start_length();
         if (len_nib == NIB_EXT8 || len_nib == NIB_EXT16) begin
            ext_acc  = '0;
            ph_count = '0;
            ph       = PH_LEN_EXT;
         end else begin
            ext_acc = 16'(len_nib);
            finish_option();
         end
      endfunction

      // predicts the records of one accepted word
      function void note_byte(coapmp_req_type w);
         logic [7:0] b;
         logic [7:0] b0;
         bit bad_len;
         b = w.data_byte;
         rec = '0;
         have = 1'b0;
         words++;
         if (ph != PH_IGNORE) parsed_bytes++;
         case (ph)
            PH_HEADER: begin
               if (ph_count < 16'd3) begin
                  hdr = {hdr[15:0], b};
                  ph_count++;
               end else begin
                  b0 = hdr[23:16];
                  rec.kind         = KIND_HEADER;
                  rec.version      = b0[7:6];
                  rec.msg_type     = b0[5:4];
                  rec.token_length = b0[3:0];
                  rec.code         = hdr[15:8];
                  rec.message_id   = {hdr[7:0], b};
                  have     = 1'b1;
                  tok_left = b0[3:0];
                  ph_count = '0;
                  ph       = (tok_left != 4'd0) ? PH_TOKEN : PH_OPT_HEAD;
               end
            end
            PH_TOKEN: begin
               if (ph_count < MAX_TOKEN_BYTES) begin
                  rec.kind       = KIND_TOKEN;
                  rec.byte_value = b;
                  have = 1'b1;
               end
               ph_count++;
               if (tok_left != 4'd0) tok_left--;
               if (tok_left == 4'd0) ph = PH_OPT_HEAD;
            end
            PH_OPT_HEAD: begin
               if (b == PAYLOAD_MARKER) begin
                  ph = PH_PAYLOAD;
               end else if (opt_seen >= opt_limit) begin
                  ph = PH_IGNORE;
               end else begin
                  delta_nib = b[7:4];
                  len_nib   = b[3:0];
                  if (delta_nib == NIB_EXT8 || delta_nib == NIB_EXT16) begin
                     ext_acc  = '0;
                     ph_count = '0;
                     ph       = PH_DELTA_EXT;
                  end else begin
                     opt_num = opt_num + 16'(delta_nib);
                     start_length();
                  end
               end
            end
            PH_DELTA_EXT: begin
               if (delta_nib == NIB_EXT8) begin
                  opt_num = opt_num + EXT8_BASE + 16'(b);
                  start_length();
               end else if (ph_count == 16'd0) begin
                  ext_acc  = 16'(b);
                  ph_count = 16'd1;
               end else begin
                  opt_num = opt_num + EXT16_BASE + {ext_acc[7:0], b};
                  start_length();
               end
            end
            PH_LEN_EXT: begin
               if (len_nib == NIB_EXT8) begin
                  ext_acc = EXT8_BASE + 16'(b);
                  finish_option();
               end else if (ph_count == 16'd0) begin
                  ext_acc  = 16'(b);
                  ph_count = 16'd1;
               end else begin
                  ext_acc = {ext_acc[7:0], b} + EXT16_BASE;
                  finish_option();
               end
            end
            PH_VALUE: begin
               rec.kind       = KIND_OPT_VALUE;
               rec.byte_value = b;
               have = 1'b1;
               if (val_left != 16'd0) val_left--;
               if (val_left == 16'd0) ph = PH_OPT_HEAD;
            end
            PH_PAYLOAD: begin
               rec.kind       = KIND_PAYLOAD;
               rec.byte_value = b;
               have = 1'b1;
               if (pay_count != 16'hFFFF) pay_count++;
            end
            default: ;
         endcase

         if (have) begin
            rec.last_result = !w.last_byte;
            records_due.push_back(rec);
         end
         if (w.last_byte) begin
            bad_len = ph inside {PH_HEADER, PH_TOKEN, PH_DELTA_EXT, PH_LEN_EXT, PH_VALUE};
            rec = '0;
            rec.kind           = KIND_END;
            rec.status         = bad_len ? STATUS_LEN_ERR : STATUS_OK;
            rec.payload_length = bad_len ? 16'd0 : pay_count;
            rec.last_result    = 1'b1;
            records_due.push_back(rec);
            messages++;
            if (bad_len) len_errors++;
            clear_state();
         end
      endfunction

      function bit field_matches(string name, logic [15:0] want, logic [15:0] got);
         if (want === got) return 1'b1;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         return 1'b0;
      endfunction

      function void check_record(coapmp_rsp_type got);
         coapmp_rsp_type want;
         bit ok;
         if (records_due.size() == 0) begin
            $display("%0t: record with none due, expected nothing, actual %h", $time, got);
            errors++;
            return;
         end
         want = records_due.pop_front();
         checked++;
         ok = field_matches("kind", 16'(want.kind), 16'(got.kind))
            & field_matches("version", 16'(want.version), 16'(got.version))
            & field_matches("msg_type", 16'(want.msg_type), 16'(got.msg_type))
            & field_matches("token_length", 16'(want.token_length), 16'(got.token_length))
            & field_matches("code", 16'(want.code), 16'(got.code))
            & field_matches("message_id", want.message_id, got.message_id)
            & field_matches("option_number", want.option_number, got.option_number)
            & field_matches("option_length", want.option_length, got.option_length)
            & field_matches("byte_value", 16'(want.byte_value), 16'(got.byte_value))
            & field_matches("status", 16'(want.status), 16'(got.status))
            & field_matches("payload_length", want.payload_length, got.payload_length)
            & field_matches("last_result", 16'(want.last_result), 16'(got.last_result));
         if (!ok) errors++;
      endfunction
   endclass

   localparam int OPTION_LIMIT = MAX_OPTIONS_DEFAULT;
   // longest quiet stretch of a correct run is a send gap plus a stall plus the pipeline
   localparam int QUIET_LIMIT  = 300;
   // words sent in total before the random phase stops
   localparam int RANDOM_BYTES = 1150;
   // past this many words both sides stop idling
   localparam int CALM_AFTER   = 900;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   coapmp_req_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   coapmp_rsp_type rsp_data;

   bit idle_on = 1'b1;
   int quiet_cycles = 0;
   logic [7:0] msg[$];

   coap_record_tracker tracker = new(OPTION_LIMIT);

   coap_message_parser #(.MAX_OPTIONS(OPTION_LIMIT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // one word per call; valid stays high into the next call unless a gap
   // is inserted, so it is never lowered and raised in one step
   task automatic send_word(coapmp_req_type w);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_byte(w);
   endtask

   // sends the bytes in msg, last mark on the final one
   task automatic send_message();
      coapmp_req_type w;
      for (int i = 0; i < msg.size(); i++) begin
         w.data_byte = msg[i];
         w.last_byte = (i == msg.size() - 1);
         send_word(w);
      end
   endtask

   // well-formed message with random content; an option whose value is long
   // is sometimes cut off, which ends the message early
   function automatic void make_message();
      int tkl, nopt, dn, ln, r, vlen;
      logic [7:0] hi, lo;
      msg.delete();
      tkl = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      msg.push_back({2'($urandom), 2'($urandom), 4'(tkl)});
      repeat (3) msg.push_back(8'($urandom));
      repeat (tkl) msg.push_back(8'($urandom));
      // now and then enough options to run into the limit
      nopt = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
      repeat (nopt) begin
         dn = $urandom_range(0, 15);
         r  = $urandom_range(0, 39);
         if (r < 26)      ln = $urandom_range(0, 3);
         else if (r < 33) ln = $urandom_range(4, 12);
         else if (r < 36) ln = NIB_EXT8;
         else if (r < 37) ln = NIB_EXT16;
         else             ln = 15;
         // both nibbles fifteen would be the marker
         if (dn == 15 && ln == 15) ln = 12;
         msg.push_back({4'(dn), 4'(ln)});
         if (dn == NIB_EXT8) msg.push_back(8'($urandom));
         if (dn == NIB_EXT16) begin
            msg.push_back(8'($urandom));
            msg.push_back(8'($urandom));
         end
         if (ln == NIB_EXT8) begin
            lo = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
            msg.push_back(lo);
            vlen = 13 + lo;
         end else if (ln == NIB_EXT16) begin
            // high byte all ones makes the 16-bit length wrap now and then
            hi = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            lo = 8'($urandom);
            msg.push_back(hi);
            msg.push_back(lo);
            vlen = int'(16'({hi, lo} + EXT16_BASE));
         end else begin
            vlen = ln;
         end
         if (vlen > 24 && (vlen > 600 || $urandom_range(0, 3) != 0)) begin
            repeat ($urandom_range(0, 5)) msg.push_back(8'($urandom));
            return;
         end
         repeat (vlen) msg.push_back(8'($urandom));
      end
      if ($urandom_range(0, 1)) begin
         msg.push_back(PAYLOAD_MARKER);
         repeat ($urandom_range(0, 14)) msg.push_back(8'($urandom));
      end
   endfunction

   // receiver side: stalls in random bursts while idling is enabled
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 6) == 0) begin
            hold = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_record(rsp_data);
   end

   // watchdog on consecutive cycles with no word accepted on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles, %0d records still due",
                     $time, QUIET_LIMIT, tracker.records_due.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int r;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: short header
      msg = '{8'h40};
      send_message();
      // all-ones header, token of fifteen cut off right away
      msg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_message();
      // extended delta, option start and end record from one word, value missing
      msg = '{8'h00, 8'h01, 8'h12, 8'h34, 8'hD1, 8'h02};
      send_message();
      // message ends inside a 16-bit length extension
      msg = '{8'h50, 8'h45, 8'h00, 8'h01, 8'hEE, 8'h01, 8'h02, 8'h03};
      send_message();
      // delta nibble fifteen, then a bare marker
      msg = '{8'h60, 8'h01, 8'hAB, 8'hCD, 8'hF1, 8'h7A, 8'hFF};
      send_message();
      // one token byte, option value ends exactly with the message
      msg = '{8'h41, 8'h02, 8'h00, 8'h00, 8'h99, 8'h11, 8'h00};
      send_message();
      // payload bytes at both extremes
      msg = '{8'h40, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF};
      send_message();

      // random messages: mostly well formed, some cut short, some noise
      while (tracker.words < RANDOM_BYTES) begin
         if (tracker.words > CALM_AFTER) idle_on = 1'b0;
         r = $urandom_range(0, 9);
         if (r == 0) begin
            msg.delete();
            repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom));
         end else begin
            make_message();
            if (r == 1 && msg.size() > 1) msg = msg[0:$urandom_range(0, msg.size() - 2)];
         end
         send_message();
      end
      idle_on = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.records_due.size() != 0) @(posedge clock);
      // then keep watching the result channel for stray records
      repeat (8) @(posedge clock);

      $display("covered %0d messages, %0d words (%0d parsed), %0d records checked",
               tracker.messages, tracker.words, tracker.parsed_bytes, tracker.checked);
      $display("  %0d length errors, %0d option starts",
               tracker.len_errors, tracker.opt_starts);
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
